FILE: rtl/pqpp_pkg.sv
// Package for the palette quantize / plane pack unit.
// Holds the fixed 16-color palette, the pipeline token type and the sizing constants.
// No dependencies.
package pqpp_pkg;

  localparam int CHAN_W       = 8;
  localparam int PAL_COUNT    = 16;
  localparam int PAL_IDX_W    = 4;
  localparam int DIST_W       = 18;   // 3 * 255 * 255 = 195075 fits in 18 bits
  localparam int GROUP_PIXELS = 8;
  localparam int GRP_CNT_W    = 3;
  localparam int PLANE_SEL_W  = 2;

  localparam logic [DIST_W-1:0] MAX_DIST  = DIST_W'(3 * 255 * 255);
  // Starting best distance: above any real distance, so entry 0 always takes it
  localparam logic [DIST_W-1:0] INIT_DIST = '1;

  typedef struct packed {
    logic                  valid;
    logic [CHAN_W-1:0]     red;
    logic [CHAN_W-1:0]     green;
    logic [CHAN_W-1:0]     blue;
    logic [DIST_W-1:0]     best_dist;
    logic [PAL_IDX_W-1:0]  best_idx;
  } pqpp_token_t;

  function automatic logic [3*CHAN_W-1:0] palette_color(input logic [PAL_IDX_W-1:0] k);
    logic [3*CHAN_W-1:0] c;
    unique case (k)
      4'd0:  c = 24'h000000;
      4'd1:  c = 24'h800000;
      4'd2:  c = 24'h008000;
      4'd3:  c = 24'h808000;
      4'd4:  c = 24'h000080;
      4'd5:  c = 24'h800080;
      4'd6:  c = 24'h008080;
      4'd7:  c = 24'hc0c0c0;
      4'd8:  c = 24'h808080;
      4'd9:  c = 24'hff0000;
      4'd10: c = 24'h00ff00;
      4'd11: c = 24'hffff00;
      4'd12: c = 24'h0000ff;
      4'd13: c = 24'hff00ff;
      4'd14: c = 24'h00ffff;
      4'd15: c = 24'hffffff;
    endcase
    return c;
  endfunction

endpackage

FILE: rtl/pqpp_cell.sv
// One cell of the nearest-color chain: compares the pixel against one palette entry.
// Depends on pqpp_pkg for the palette and the token type.
module pqpp_cell
  import pqpp_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 en,
  input  logic [PAL_IDX_W-1:0] entry,
  input  pqpp_token_t          tok_in,
  output pqpp_token_t          tok_out
);

  logic [3*CHAN_W-1:0] color;
  logic [CHAN_W-1:0]   dr, dg, db;
  logic [2*CHAN_W-1:0] sr, sg, sb;
  logic [DIST_W-1:0]   entry_dist;

  function automatic logic [CHAN_W-1:0] abs_diff(input logic [CHAN_W-1:0] a,
                                                 input logic [CHAN_W-1:0] b);
    return (a >= b) ? (a - b) : (b - a);
  endfunction

  always_comb begin
    color      = palette_color(entry);
    dr         = abs_diff(tok_in.red,   color[3*CHAN_W-1:2*CHAN_W]);
    dg         = abs_diff(tok_in.green, color[2*CHAN_W-1:CHAN_W]);
    db         = abs_diff(tok_in.blue,  color[CHAN_W-1:0]);
    sr         = (2*CHAN_W)'(dr) * (2*CHAN_W)'(dr);
    sg         = (2*CHAN_W)'(dg) * (2*CHAN_W)'(dg);
    sb         = (2*CHAN_W)'(db) * (2*CHAN_W)'(db);
    entry_dist = DIST_W'(sr) + DIST_W'(sg) + DIST_W'(sb);
  end

  // Ties go to the later entry, so take the new one on equal distance
  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.valid <= 1'b0;
    end else if (en) begin
      tok_out.valid <= tok_in.valid;
    end
    if (en) begin
      tok_out.red   <= tok_in.red;
      tok_out.green <= tok_in.green;
      tok_out.blue  <= tok_in.blue;
      if (entry_dist <= tok_in.best_dist) begin
        tok_out.best_dist <= entry_dist;
        tok_out.best_idx  <= entry;
      end else begin
        tok_out.best_dist <= tok_in.best_dist;
        tok_out.best_idx  <= tok_in.best_idx;
      end
    end
  end

endmodule

FILE: rtl/pqpp_packer.sv
// Plane packer: gathers the selected index bit of eight pixels into one byte.
// Depends on pqpp_pkg; holds the output register of the unit.
module pqpp_packer
  import pqpp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   en,
  input  logic [PLANE_SEL_W-1:0] plane_select,
  input  pqpp_token_t            tok_in,
  output logic                   out_valid,
  output logic [GROUP_PIXELS-1:0] out_byte
);

  logic [GRP_CNT_W-1:0]    count;
  logic [GROUP_PIXELS-2:0] partial;
  logic [GROUP_PIXELS-1:0] acc;
  logic                    last;

  assign acc  = {partial, tok_in.best_idx[plane_select]};
  assign last = (count == GRP_CNT_W'(GROUP_PIXELS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      partial   <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= tok_in.valid && last;
      if (tok_in.valid) begin
        if (last) begin
          count   <= '0;
          partial <= '0;
        end else begin
          count   <= count + GRP_CNT_W'(1);
          partial <= acc[GROUP_PIXELS-2:0];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en && tok_in.valid && last) begin
      out_byte <= acc;
    end
  end

endmodule

FILE: rtl/palette_quantize_plane_pack_unit.sv
// Top level of the palette quantize / plane pack unit.
// Depends on pqpp_pkg, pqpp_cell and pqpp_packer.
//
// Takes one RGB pixel per clock and maps it to the nearest of sixteen fixed palette
// colors (squared distance, ties to the higher index). The chosen plane_select bit of
// each index is packed, eight pixels per byte, first pixel in bit 7. A pixel passes
// a chain of 16 cells, one palette entry per cell, then the packer: the byte is valid
// on m_tdata once the eighth pixel of its group has left the last cell and been
// registered in the packer. A new pixel is taken every clock; the whole chain stalls
// only while a finished byte waits on m_tready. Write plane_select only while the
// unit is idle; cfg_ready is always high.
module palette_quantize_plane_pack_unit
  import pqpp_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [3*CHAN_W-1:0]    s_tdata,   // red [7:0], green [15:8], blue [23:16]
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [GROUP_PIXELS-1:0] m_tdata,  // plane_byte [7:0]
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [PLANE_SEL_W-1:0] cfg_data
);

  logic                   en;
  logic [PLANE_SEL_W-1:0] plane_select;
  pqpp_token_t            chain [0:PAL_COUNT];

  // Advance everything when the output slot is free or being emptied
  assign en        = !m_tvalid || m_tready;
  assign s_tready  = en;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      plane_select <= '0;
    end else if (cfg_valid && cfg_ready) begin
      plane_select <= cfg_data;
    end
  end

  always_comb begin
    chain[0].valid     = s_tvalid;
    chain[0].red       = s_tdata[CHAN_W-1:0];
    chain[0].green     = s_tdata[2*CHAN_W-1:CHAN_W];
    chain[0].blue      = s_tdata[3*CHAN_W-1:2*CHAN_W];
    chain[0].best_dist = INIT_DIST;
    chain[0].best_idx  = '0;
  end

  for (genvar k = 0; k < PAL_COUNT; k++) begin : g_cell
    pqpp_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .en      (en),
      .entry   (PAL_IDX_W'(k)),
      .tok_in  (chain[k]),
      .tok_out (chain[k+1])
    );
  end

  pqpp_packer u_packer (
    .clk          (clk),
    .rst          (rst),
    .en           (en),
    .plane_select (plane_select),
    .tok_in       (chain[PAL_COUNT]),
    .out_valid    (m_tvalid),
    .out_byte     (m_tdata)
  );

`ifndef NO_ASSERTIONS
  // An accepted pixel must enter the first cell
  a_enter: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> chain[1].valid)
    else $error("accepted pixel did not enter the chain");

  // The chain tail always carries a real distance, never the starting value
  a_dist: assert property (@(posedge clk) disable iff (rst)
    chain[PAL_COUNT].valid |-> chain[PAL_COUNT].best_dist <= MAX_DIST)
    else $error("chain tail distance out of range");

  // A new byte only appears after a pixel left the chain tail
  a_byte: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(chain[PAL_COUNT].valid))
    else $error("byte produced without a finishing pixel");
`endif

endmodule
